// ===== rtl/fcst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcst_pkg: shared types and constants of the floor/ceiling span texturer
// item and result layouts, mode codes, register indexes, default sizes
// ----------------------------------------------------------------------------
package fcst_pkg;

    // default sizes for the top-level parameters
    localparam int MAX_TEX_LOG2_DEF    = 6;
    localparam int MAX_FRAME_WIDTH_DEF = 1024;

    // fixed widths
    localparam int FRAC_BITS   = 16;
    localparam int ADDR_W      = 20;
    localparam int COLOR_W     = 16;
    localparam int TEXEL_W     = 8;
    localparam int PAL_AW      = 8;
    localparam int COUNT_W     = 11;
    localparam int COORD_W     = 10;
    localparam int ACC_W       = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 11;

    // item modes
    typedef enum logic [2:0] {
        MODE_FLOOR_LOAD   = 3'd0,
        MODE_CEILING_LOAD = 3'd1,
        MODE_PALETTE_LOAD = 3'd2,
        MODE_SPAN_START   = 3'd3,
        MODE_STEP         = 3'd4
    } mode_t;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEX_LOG2    = 1'b1;

    // reset values of the registers
    localparam logic [10:0] FRAME_WIDTH_RST = 11'd320;
    localparam logic [2:0]  TEX_LOG2_RST    = 3'd6;

    typedef struct packed {
        logic [2:0]         mode;
        logic [11:0]        load_index;
        logic [15:0]        load_value;
        logic [9:0]         floor_row;
        logic [9:0]         ceiling_row;
        logic [9:0]         x_start;
        logic [9:0]         x_end;
        logic signed [31:0] s_start;
        logic signed [31:0] t_start;
        logic signed [31:0] s_step;
        logic signed [31:0] t_step;
    } item_t;

    typedef struct packed {
        logic [19:0] floor_address;
        logic [15:0] floor_color;
        logic [19:0] ceiling_address;
        logic [15:0] ceiling_color;
        logic        last_pixel;
    } result_t;

    // control from the span pipeline to the texture stores
    typedef struct packed {
        logic floor_we;
        logic ceiling_we;
        logic palette_we;
        logic texel_read;
        logic palette_read;
    } mem_ctrl_t;

endpackage

// ===== rtl/floor_ceiling_span_texturer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// floor_ceiling_span_texturer: affine textured floor and ceiling spans
// loads fill the texel stores and palette, a span start latches the span,
// each step on a span with pixels left emits one floor pixel and one ceiling pixel
// ----------------------------------------------------------------------------
// a step's result is registered in stage 1, then in the output register (stage 2)
// throughput: one item per cycle while the result channel does not stall; set by the texel read then palette read chain
// the output register lets one more item in while a result waits at a stall
// reset: config goes to pitch 320 and texture log2 6, span state and
// pipeline valids clear; texel and palette stores are not cleared
// ----------------------------------------------------------------------------
module floor_ceiling_span_texturer #(
    parameter int MAX_TEX_LOG2    = fcst_pkg::MAX_TEX_LOG2_DEF,
    parameter int MAX_FRAME_WIDTH = fcst_pkg::MAX_FRAME_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // item channel
    input  logic                                item_valid,
    output logic                                item_stall,
    input  fcst_pkg::item_t                     item,
    // result channel
    output logic                                result_valid,
    input  logic                                result_stall,
    output fcst_pkg::result_t                   result,
    // register write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fcst_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [fcst_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import fcst_pkg::*;

    localparam int TEX_AW  = 2 * MAX_TEX_LOG2;
    localparam int L_W     = $clog2(MAX_TEX_LOG2 + 1);
    localparam int PITCH_W = $clog2(MAX_FRAME_WIDTH + 1);
    localparam int LIN_W   = COORD_W + PITCH_W + 1;

    // config registers
    logic [10:0] frame_width_reg;
    logic [2:0]  tex_log2_reg;

    // span state
    logic [ACC_W-1:0]   s_accum_reg,   s_accum_next;
    logic [ACC_W-1:0]   t_accum_reg,   t_accum_next;
    logic [ACC_W-1:0]   s_inc_reg,     s_inc_next;
    logic [ACC_W-1:0]   t_inc_reg,     t_inc_next;
    logic [ADDR_W-1:0]  floor_ptr_reg, floor_ptr_next;
    logic [ADDR_W-1:0]  ceil_ptr_reg,  ceil_ptr_next;
    logic [COUNT_W-1:0] left_reg,      left_next;

    // pipeline: stage 1 waits on texel data, stage 2 is the output register
    logic              v1_reg, v1_next;
    logic              v2_reg, v2_next;
    logic [ADDR_W-1:0] s1_floor_addr_reg, s1_ceil_addr_reg;
    logic              s1_last_reg;
    logic [ADDR_W-1:0] s2_floor_addr_reg, s2_ceil_addr_reg;
    logic              s2_last_reg;

    logic hold2, move1, accept, is_step, emit;

    logic [L_W-1:0]     edge_l;
    logic [4:0]         tex_shift;
    logic [ACC_W-1:0]   tex_mask, s_col, t_row, texel_idx;
    logic [PITCH_W-1:0] pitch;
    logic [LIN_W-1:0]   floor_lin, ceil_lin;
    logic [31:0]        load_index_ext;

    mem_ctrl_t              mem_ctrl;
    logic [COLOR_W-1:0]     floor_color, ceiling_color;

    // ---------------------------------------------------------------- handshake
    // stage 2 holds while its result is stalled; stage 1 moves when 2 frees up
    assign hold2      = v2_reg && result_stall;
    assign move1      = v1_reg && !hold2;
    // take items unless stage 1 is full and cannot move
    assign item_stall = v1_reg && hold2;
    assign accept     = item_valid && !item_stall;
    assign is_step    = (item.mode == MODE_STEP);
    assign emit       = accept && is_step && (left_reg != '0);

    assign cfg_ready  = 1'b1;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= FRAME_WIDTH_RST;
            tex_log2_reg    <= TEX_LOG2_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FRAME_WIDTH: frame_width_reg <= cfg_data;
                CFG_TEX_LOG2:    tex_log2_reg    <= cfg_data[2:0];
                default:         ;
            endcase
        end
    end

    // ---------------------------------------------------------------- texel index
    // texture edge log2, saturated to 1..MAX_TEX_LOG2
    always_comb
    begin
        if (tex_log2_reg == 3'd0)
        begin
            edge_l = L_W'(1);
        end
        else if (32'(tex_log2_reg) > MAX_TEX_LOG2)
        begin
            edge_l = L_W'(MAX_TEX_LOG2);
        end
        else
        begin
            edge_l = L_W'(tex_log2_reg);
        end
    end

    // row of t over column of s, each (acc >> (16 - l)) masked to the edge
    assign tex_shift = 5'(FRAC_BITS) - 5'(edge_l);
    assign tex_mask  = (ACC_W'(1) << edge_l) - ACC_W'(1);
    assign s_col     = (s_accum_reg >> tex_shift) & tex_mask;
    assign t_row     = (t_accum_reg >> tex_shift) & tex_mask;
    assign texel_idx = (t_row << edge_l) | s_col;

    // ---------------------------------------------------------------- span start
    // row pitch, saturated to 1..MAX_FRAME_WIDTH
    always_comb
    begin
        if (frame_width_reg == 11'd0)
        begin
            pitch = PITCH_W'(1);
        end
        else if (32'(frame_width_reg) > MAX_FRAME_WIDTH)
        begin
            pitch = PITCH_W'(MAX_FRAME_WIDTH);
        end
        else
        begin
            pitch = PITCH_W'(frame_width_reg);
        end
    end

    assign floor_lin = LIN_W'(item.floor_row) * LIN_W'(pitch) + LIN_W'(item.x_start);
    assign ceil_lin  = LIN_W'(item.ceiling_row) * LIN_W'(pitch) + LIN_W'(item.x_start);

    // ---------------------------------------------------------------- span state
    always_comb
    begin
        s_accum_next   = s_accum_reg;
        t_accum_next   = t_accum_reg;
        s_inc_next     = s_inc_reg;
        t_inc_next     = t_inc_reg;
        floor_ptr_next = floor_ptr_reg;
        ceil_ptr_next  = ceil_ptr_reg;
        left_next      = left_reg;
        if (accept && (item.mode == MODE_SPAN_START))
        begin
            // a new span replaces whatever is active
            s_accum_next   = $unsigned(item.s_start);
            t_accum_next   = $unsigned(item.t_start);
            s_inc_next     = $unsigned(item.s_step);
            t_inc_next     = $unsigned(item.t_step);
            floor_ptr_next = ADDR_W'(floor_lin);
            ceil_ptr_next  = ADDR_W'(ceil_lin);
            if (item.x_end >= item.x_start)
            begin
                left_next = COUNT_W'(item.x_end) - COUNT_W'(item.x_start) + COUNT_W'(1);
            end
            else
            begin
                left_next = '0;
            end
        end
        else if (emit)
        begin
            // accumulators wrap mod 2^32, pointers wrap at 20 bits
            s_accum_next   = s_accum_reg + s_inc_reg;
            t_accum_next   = t_accum_reg + t_inc_reg;
            floor_ptr_next = floor_ptr_reg + ADDR_W'(1);
            ceil_ptr_next  = ceil_ptr_reg + ADDR_W'(1);
            left_next      = left_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_accum_reg   <= '0;
            t_accum_reg   <= '0;
            s_inc_reg     <= '0;
            t_inc_reg     <= '0;
            floor_ptr_reg <= '0;
            ceil_ptr_reg  <= '0;
            left_reg      <= '0;
        end
        else
        begin
            s_accum_reg   <= s_accum_next;
            t_accum_reg   <= t_accum_next;
            s_inc_reg     <= s_inc_next;
            t_inc_reg     <= t_inc_next;
            floor_ptr_reg <= floor_ptr_next;
            ceil_ptr_reg  <= ceil_ptr_next;
            left_reg      <= left_next;
        end
    end

    // ---------------------------------------------------------------- pipeline valids
    always_comb
    begin
        if (emit)
        begin
            v1_next = 1'b1;
        end
        else if (move1)
        begin
            v1_next = 1'b0;
        end
        else
        begin
            v1_next = v1_reg;
        end

        if (move1)
        begin
            v2_next = 1'b1;
        end
        else if (!hold2)
        begin
            // taken or empty
            v2_next = 1'b0;
        end
        else
        begin
            v2_next = v2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    // pipeline payload, no reset
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            s1_floor_addr_reg <= floor_ptr_reg;
            s1_ceil_addr_reg  <= ceil_ptr_reg;
            s1_last_reg       <= (left_reg == COUNT_W'(1));
        end
        if (move1)
        begin
            s2_floor_addr_reg <= s1_floor_addr_reg;
            s2_ceil_addr_reg  <= s1_ceil_addr_reg;
            s2_last_reg       <= s1_last_reg;
        end
    end

    // ---------------------------------------------------------------- texture stores
    // loads write at their transfer; a step reads texels at its transfer and
    // the palette when it moves to the output register, so every read lands
    // in item order against the writes
    assign load_index_ext        = 32'(item.load_index);
    assign mem_ctrl.floor_we     = accept && (item.mode == MODE_FLOOR_LOAD);
    assign mem_ctrl.ceiling_we   = accept && (item.mode == MODE_CEILING_LOAD);
    assign mem_ctrl.palette_we   = accept && (item.mode == MODE_PALETTE_LOAD);
    assign mem_ctrl.texel_read   = emit;
    assign mem_ctrl.palette_read = move1;

    fcst_texmem #(
        .MAX_TEX_LOG2 (MAX_TEX_LOG2)
    ) u_texmem (
        .clk           (clk),
        .ctrl          (mem_ctrl),
        .tex_waddr     (load_index_ext[TEX_AW-1:0]),
        .pal_waddr     (item.load_index[PAL_AW-1:0]),
        .wdata         (item.load_value),
        .tex_raddr     (texel_idx[TEX_AW-1:0]),
        .floor_color   (floor_color),
        .ceiling_color (ceiling_color)
    );

    // ---------------------------------------------------------------- result
    assign result_valid           = v2_reg;
    assign result.floor_address   = s2_floor_addr_reg;
    assign result.floor_color     = floor_color;
    assign result.ceiling_address = s2_ceil_addr_reg;
    assign result.ceiling_color   = ceiling_color;
    assign result.last_pixel      = s2_last_reg;

    // ---------------------------------------------------------------- checks
    // a step on the last pixel empties the span
    a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (left_reg == COUNT_W'(1))) |=> (left_reg == '0))
        else $error("span count not cleared after last pixel");

    // items are refused only with both pipeline stages full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (v1_reg && v2_reg))
        else $error("item stall with a free pipeline stage");

    // a pixel that enters stage 1 is there the next cycle
    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> v1_reg)
        else $error("emitted pixel lost from stage 1");

    // stage 1 moving fills the output register
    a_move_lands: assert property (@(posedge clk) disable iff (!rst_n)
        move1 |=> result_valid)
        else $error("pixel lost between stage 1 and output");

    // a stalled result keeps its address
    a_hold_addr: assert property (@(posedge clk) disable iff (!rst_n)
        hold2 |=> $stable(s2_floor_addr_reg))
        else $error("held result changed");

endmodule

// ===== rtl/fcst_texmem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcst_texmem: texel stores and palette of the span texturer
// two texel memories read at one index, then a dual-read palette lookup
// ----------------------------------------------------------------------------
module fcst_texmem #(
    parameter int MAX_TEX_LOG2 = fcst_pkg::MAX_TEX_LOG2_DEF
) (
    input  logic                                clk,
    input  fcst_pkg::mem_ctrl_t                 ctrl,
    input  logic [2*MAX_TEX_LOG2-1:0]           tex_waddr,
    input  logic [fcst_pkg::PAL_AW-1:0]         pal_waddr,
    input  logic [fcst_pkg::COLOR_W-1:0]        wdata,
    input  logic [2*MAX_TEX_LOG2-1:0]           tex_raddr,
    output logic [fcst_pkg::COLOR_W-1:0]        floor_color,
    output logic [fcst_pkg::COLOR_W-1:0]        ceiling_color
);
    import fcst_pkg::*;

    localparam int TEX_AW    = 2 * MAX_TEX_LOG2;
    localparam int TEX_DEPTH = 1 << TEX_AW;
    localparam int PAL_DEPTH = 1 << PAL_AW;

    logic [TEXEL_W-1:0] floor_mem   [TEX_DEPTH];
    logic [TEXEL_W-1:0] ceiling_mem [TEX_DEPTH];
    logic [COLOR_W-1:0] pal_mem     [PAL_DEPTH];

    logic [TEXEL_W-1:0] floor_texel_reg;
    logic [TEXEL_W-1:0] ceiling_texel_reg;
    logic [COLOR_W-1:0] floor_color_reg;
    logic [COLOR_W-1:0] ceiling_color_reg;

    // texel stores: one write port, one read port each
    always_ff @(posedge clk)
    begin
        if (ctrl.floor_we)
        begin
            floor_mem[tex_waddr] <= wdata[TEXEL_W-1:0];
        end
        if (ctrl.ceiling_we)
        begin
            ceiling_mem[tex_waddr] <= wdata[TEXEL_W-1:0];
        end
        if (ctrl.texel_read)
        begin
            floor_texel_reg   <= floor_mem[tex_raddr];
            ceiling_texel_reg <= ceiling_mem[tex_raddr];
        end
    end

    // palette: one write port, two read ports; a read at the write edge sees old data
    always_ff @(posedge clk)
    begin
        if (ctrl.palette_we)
        begin
            pal_mem[pal_waddr] <= wdata;
        end
        if (ctrl.palette_read)
        begin
            floor_color_reg   <= pal_mem[floor_texel_reg];
            ceiling_color_reg <= pal_mem[ceiling_texel_reg];
        end
    end

    assign floor_color   = floor_color_reg;
    assign ceiling_color = ceiling_color_reg;

endmodule
